>>> src/wht_pkg.sv
// Shared types and constants for the water heater thermostat.
// No dependencies; imported by wht_core and water_heater_thermostat.
`default_nettype none
package wht_pkg;

  // Item and register codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_POWER = 2'd1;
  localparam logic [1:0] OP_UP    = 2'd2;
  localparam logic [1:0] OP_DOWN  = 2'd3;

  localparam logic REG_TICKS_PER_SAMPLE = 1'b0;
  localparam logic REG_INITIAL_SETPOINT = 1'b1;

  // Timing constants, counted in samples
  localparam int unsigned WINDOW_SAMPLES          = 10;
  localparam int unsigned SETTING_TIMEOUT_SAMPLES = 50;
  localparam logic [3:0]  BLINK_SAMPLES           = 4'd10;

  // Window average: divide by reciprocal multiply, 15 fraction bits
  localparam int unsigned RECIP_SHIFT = 15;
  localparam logic [15:0] WIN_RECIP =
    16'(((1 << RECIP_SHIFT) + WINDOW_SAMPLES - 1) / WINDOW_SAMPLES);

  // Setpoint range and dead band
  localparam logic [7:0] SP_MIN  = 8'd35;
  localparam logic [7:0] SP_MAX  = 8'd75;
  localparam logic [7:0] SP_STEP = 8'd5;
  localparam logic [8:0] BAND    = 9'd5;

  // Reset values of the configuration registers
  localparam logic [15:0] TICKS_RESET    = 16'd4;
  localparam logic [6:0]  SETPOINT_RESET = 7'd60;

  typedef enum logic [1:0] {
    HM_IDLE = 2'd0,
    HM_HEAT = 2'd1,
    HM_COOL = 2'd2
  } heat_mode_e;

  typedef struct packed {
    logic [15:0] prescale_count;
    logic [11:0] sample_sum;
    logic [3:0]  samples_in_window;
    logic [7:0]  average_temp;
    logic [7:0]  last_sample;
    logic [6:0]  setpoint;
    logic        powered;
    logic        setting_mode;
    logic [5:0]  setting_timeout;
    heat_mode_e  heat_mode;
    logic [3:0]  display_blink_count;
    logic        display_phase;
    logic [3:0]  led_blink_count;
    logic        led_phase;
  } wht_state_t;

  typedef struct packed {
    logic       heater_on;
    logic       cooler_on;
    logic       indicator_on;
    logic [7:0] display_value;
    logic       display_lit;
    logic       setting_active;
    logic       save_request;
    logic [6:0] setpoint_out;
  } wht_result_t;

endpackage
`default_nettype wire

>>> src/wht_core.sv
// Thermostat state registers and the single-pass next-state/result logic.
// Depends on wht_pkg.
`default_nettype none
module wht_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [1:0]          op_i,
  input  wire logic [7:0]          smp_i,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [15:0]         cfg_data_i,
  output wht_pkg::wht_result_t     res_o
);
  import wht_pkg::*;

  wht_state_t  s_q, s_d;
  logic [15:0] tps_q;

  logic [15:0] pc_inc;
  logic [11:0] sum_inc;
  logic [3:0]  win_inc;
  logic [3:0]  dbc_inc;
  logic [3:0]  lbc_inc;
  logic [5:0]  to_inc;
  logic [27:0] avg_prod;
  logic [7:0]  sp_up;
  logic [7:0]  sp_dn;
  logic [8:0]  avg_band;
  logic [8:0]  sp_band;
  logic        save;

  // Window sum times reciprocal gives the average
  assign sum_inc  = s_q.sample_sum + 12'(smp_i);
  assign avg_prod = 28'(sum_inc) * 28'(WIN_RECIP);

  // Next state for one item
  always_comb begin
    s_d     = s_q;
    save    = 1'b0;
    pc_inc  = s_q.prescale_count + 16'd1;
    win_inc = s_q.samples_in_window + 4'd1;
    to_inc  = s_q.setting_timeout + 6'd1;
    dbc_inc = s_q.display_blink_count + 4'd1;
    lbc_inc = s_q.led_blink_count + 4'd1;
    sp_up   = {1'b0, s_q.setpoint} + SP_STEP;
    sp_dn   = {1'b0, s_q.setpoint} - SP_STEP;

    case (op_i)
      OP_TICK: begin
        s_d.prescale_count = pc_inc;
        if (pc_inc == tps_q) begin
          s_d.prescale_count    = '0;
          s_d.last_sample       = smp_i;
          s_d.sample_sum        = sum_inc;
          s_d.samples_in_window = win_inc;
          if (s_q.setting_mode) begin
            s_d.setting_timeout = to_inc;
          end
          if (s_q.powered && s_q.setting_mode) begin
            s_d.display_blink_count = dbc_inc;
          end
          if (s_q.heat_mode == HM_HEAT) begin
            s_d.led_blink_count = lbc_inc;
          end
          if (s_d.display_blink_count == BLINK_SAMPLES) begin
            s_d.display_phase       = ~s_q.display_phase;
            s_d.display_blink_count = '0;
          end
          if (s_d.led_blink_count == BLINK_SAMPLES) begin
            s_d.led_phase       = ~s_q.led_phase;
            s_d.led_blink_count = '0;
          end
          if (win_inc == 4'(WINDOW_SAMPLES)) begin
            s_d.average_temp      = avg_prod[RECIP_SHIFT +: 8];
            s_d.sample_sum        = '0;
            s_d.samples_in_window = '0;
          end
          if (s_q.setting_mode && s_d.setting_timeout == 6'(SETTING_TIMEOUT_SAMPLES)) begin
            s_d.setting_mode    = 1'b0;
            s_d.setting_timeout = '0;
          end
        end
      end
      OP_POWER: begin
        s_d.powered = ~s_q.powered;
      end
      OP_UP, OP_DOWN: begin
        if (!s_q.setting_mode) begin
          s_d.setting_mode = 1'b1;
        end else begin
          save                = 1'b1;
          s_d.setting_timeout = '0;
          if (op_i == OP_UP) begin
            if (sp_up > SP_MAX)      s_d.setpoint = SP_MAX[6:0];
            else if (sp_up < SP_MIN) s_d.setpoint = SP_MIN[6:0];
            else                     s_d.setpoint = sp_up[6:0];
          end else begin
            // below the step, or landing under the floor, both clamp to min
            if ({1'b0, s_q.setpoint} < SP_MIN + SP_STEP) s_d.setpoint = SP_MIN[6:0];
            else if (sp_dn > SP_MAX)                     s_d.setpoint = SP_MAX[6:0];
            else                                         s_d.setpoint = sp_dn[6:0];
          end
        end
      end
      default: begin
        s_d = s_q;
      end
    endcase

    // Bang-bang control with dead band
    avg_band = {1'b0, s_d.average_temp} + BAND;
    sp_band  = {2'b00, s_d.setpoint} + BAND;
    if (!s_d.powered) begin
      s_d.heat_mode = HM_IDLE;
      s_d.led_phase = 1'b0;
    end else if (avg_band <= {2'b00, s_d.setpoint}) begin
      s_d.heat_mode = HM_HEAT;
    end else if ({1'b0, s_d.average_temp} >= sp_band) begin
      s_d.heat_mode = HM_COOL;
      s_d.led_phase = 1'b1;
    end
  end

  // Result describes the state after the item
  always_comb begin
    res_o.heater_on      = s_d.powered && (s_d.heat_mode == HM_HEAT);
    res_o.cooler_on      = s_d.powered && (s_d.heat_mode == HM_COOL);
    res_o.indicator_on   = s_d.powered && s_d.led_phase;
    res_o.display_value  = s_d.setting_mode ? {1'b0, s_d.setpoint} : s_d.last_sample;
    res_o.display_lit    = s_d.powered && (!s_d.setting_mode || s_d.display_phase);
    res_o.setting_active = s_d.setting_mode;
    res_o.save_request   = save;
    res_o.setpoint_out   = s_d.setpoint;
  end

  // State and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q   <= '{setpoint: SETPOINT_RESET, heat_mode: HM_IDLE, display_phase: 1'b1,
                 default: '0};
      tps_q <= TICKS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_TICKS_PER_SAMPLE) begin
        tps_q <= cfg_data_i;
      end else begin
        s_q.setpoint <= cfg_data_i[6:0];
      end
    end else if (step_i) begin
      s_q <= s_d;
    end
  end

endmodule
`default_nettype wire

>>> src/water_heater_thermostat.sv
// Water heater thermostat top level: input register, core, result register.
// Depends on wht_pkg and wht_core.
// A word taken into the input register passes through the core into the result register.
// Throughput: one word per cycle; a stalled result holds one more word in the
// input register, then in_ready_o drops until the result is taken.
// Reset: asynchronous, clears all control state but display_phase (set), setpoint 60, sample period 4.
`default_nettype none
module water_heater_thermostat (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output wire logic        in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  sensor_sample_i,
  output wire logic        out_valid_o,
  input  wire logic        out_ready_i,
  output wire logic        heater_on_o,
  output wire logic        cooler_on_o,
  output wire logic        indicator_on_o,
  output wire logic [7:0]  display_value_o,
  output wire logic        display_lit_o,
  output wire logic        setting_active_o,
  output wire logic        save_request_o,
  output wire logic [6:0]  setpoint_out_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import wht_pkg::*;

  logic        in_valid_q;
  logic [1:0]  op_q;
  logic [7:0]  smp_q;
  logic        out_valid_q;
  wht_result_t res_q;
  wht_result_t res;
  logic        advance;

  // Word moves from input register to result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q  <= operation_i;
      smp_q <= sensor_sample_i;
    end
  end

  wht_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .op_i       (op_q),
    .smp_i      (smp_q),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign heater_on_o      = res_q.heater_on;
  assign cooler_on_o      = res_q.cooler_on;
  assign indicator_on_o   = res_q.indicator_on;
  assign display_value_o  = res_q.display_value;
  assign display_lit_o    = res_q.display_lit;
  assign setting_active_o = res_q.setting_active;
  assign save_request_o   = res_q.save_request;
  assign setpoint_out_o   = res_q.setpoint_out;

endmodule
`default_nettype wire
